@@ design/tdfws_pkg.sv @@
// Shared types and constants for the tail-drop FIFO with watermark status.
// No dependencies; imported by the core module.
`timescale 1ns / 1ps

package tdfws_pkg;

    // Default geometry
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int TAG_WIDTH_DEF   = 32;

    // Request opcodes
    localparam logic OP_ARRIVE  = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result kinds
    localparam logic [1:0] RES_ACCEPTED = 2'd0;
    localparam logic [1:0] RES_DROPPED  = 2'd1;
    localparam logic [1:0] RES_DEQUEUED = 2'd2;
    localparam logic [1:0] RES_EMPTY    = 2'd3;

    // Queue entry kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_CONGESTED = 2'd1;
    localparam logic [1:0] KIND_RELIEVED  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [1:0] CFG_HIGH_MARK = 2'd1;
    localparam logic [1:0] CFG_LOW_MARK  = 2'd2;

    // Configuration reset values
    localparam logic [7:0] CAPACITY_RST  = 8'd200;
    localparam logic [7:0] HIGH_MARK_RST = 8'd160;
    localparam logic [7:0] LOW_MARK_RST  = 8'd50;

    typedef struct packed {
        logic        opcode;
        logic [31:0] packet_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  item_kind;
        logic [31:0] item_tag;
        logic [8:0]  occupancy;
    } rsp_t;

endpackage

@@ design/tail_drop_fifo_watermark_status_core.sv @@
// Drops, empty dequeues and plain arrivals go from idle to the finish state; dequeues
// pass a read state for the registered memory read; a status insert adds a data-write
// state, since the single write port takes the status and the data entry in turn.
// A new request is taken only once the previous response is registered.
// Reset: asynchronous; clears the head pointer, count and congestion flag, loads
// capacity 200, high mark 160 and low mark 50; the queue memory is not cleared.
`timescale 1ns / 1ps

module tail_drop_fifo_watermark_status_core
    import tdfws_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int MW = (CW > 8) ? CW : 8;
    localparam int EW = TAG_WIDTH + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WDATA,
        S_READ,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          head_reg;
    logic [CW-1:0]          count_reg;
    logic                   cong_reg;
    logic [7:0]             capacity_reg;
    logic [7:0]             high_mark_reg;
    logic [7:0]             low_mark_reg;
    logic [TAG_WIDTH-1:0]   tag_reg;
    logic [1:0]             res_kind_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    // Queue memory
    logic [EW-1:0]          mem [QUEUE_DEPTH];
    logic [EW-1:0]          rd_data_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic                   rd_en;

    logic                   req_fire;
    logic                   out_free;
    logic [SW-1:0]          tail_sum;
    logic [AW-1:0]          tail_addr;
    logic [AW-1:0]          head_dec;
    logic [AW-1:0]          head_inc;
    logic                   is_empty;
    logic                   drop;
    logic                   room;
    logic                   cong_hit;
    logic                   rel_hit;
    logic                   status_push;
    logic [AW-1:0]          status_addr;
    logic [1:0]             rd_kind;
    logic [TAG_WIDTH-1:0]   rd_tag;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Ring pointer arithmetic; head + count stays below twice the depth
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : AW'(tail_sum);
    assign head_dec  = (head_reg == '0) ? AW'(QUEUE_DEPTH - 1) : head_reg - AW'(1);
    assign head_inc  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Admission and watermark decisions on the current count
    assign is_empty    = (count_reg == '0);
    assign drop        = (MW'(count_reg) >= MW'(capacity_reg))
                         || (count_reg >= CW'(QUEUE_DEPTH));
    assign room        = (count_reg <= CW'(QUEUE_DEPTH - 2));
    assign cong_hit    = (MW'(count_reg) >= MW'(high_mark_reg)) && !cong_reg;
    assign rel_hit     = (MW'(count_reg) < MW'(low_mark_reg)) && cong_reg;
    assign status_push = room && (cong_hit || rel_hit);
    assign status_addr = is_empty ? head_reg : head_dec;

    assign rd_kind = rd_data_reg[EW-1:TAG_WIDTH];
    assign rd_tag  = rd_data_reg[TAG_WIDTH-1:0];

    // Select the memory write: status or data on accept, data after a status
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = tail_addr;
        wr_data = {KIND_DATA, tag_reg};
        if (state_reg == S_IDLE && req_fire && req.opcode == OP_ARRIVE && !drop)
        begin
            wr_en = 1'b1;
            if (status_push)
            begin
                wr_addr = status_addr;
                wr_data = {(cong_hit ? KIND_CONGESTED : KIND_RELIEVED), TAG_WIDTH'(0)};
            end
            else
            begin
                wr_data = {KIND_DATA, TAG_WIDTH'(req.packet_tag)};
            end
        end
        else if (state_reg == S_WDATA)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_en = req_fire && (req.opcode == OP_DEQUEUE) && !is_empty;

    // Write and read the queue memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    // Sequence each request and hold the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cong_reg      <= 1'b0;
            capacity_reg  <= CAPACITY_RST;
            high_mark_reg <= HIGH_MARK_RST;
            low_mark_reg  <= LOW_MARK_RST;
            tag_reg       <= '0;
            res_kind_reg  <= RES_ACCEPTED;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY:  capacity_reg  <= cfg_data;
                    CFG_HIGH_MARK: high_mark_reg <= cfg_data;
                    CFG_LOW_MARK:  low_mark_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // Drop a taken response unless the next one loads in its place
            if (rsp_valid_reg && rsp_ready && state_reg != S_READ && state_reg != S_FIN)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        tag_reg <= TAG_WIDTH'(req.packet_tag);
                        if (req.opcode == OP_DEQUEUE)
                        begin
                            if (is_empty)
                            begin
                                res_kind_reg <= RES_EMPTY;
                                state_reg    <= S_FIN;
                            end
                            else
                            begin
                                head_reg  <= head_inc;
                                count_reg <= count_reg - CW'(1);
                                state_reg <= S_READ;
                            end
                        end
                        else if (drop)
                        begin
                            res_kind_reg <= RES_DROPPED;
                            state_reg    <= S_FIN;
                        end
                        else
                        begin
                            res_kind_reg <= RES_ACCEPTED;
                            count_reg    <= count_reg + CW'(1);
                            if (status_push)
                            begin
                                cong_reg <= cong_hit;
                                if (!is_empty)
                                begin
                                    head_reg <= head_dec;
                                end
                                state_reg <= S_WDATA;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                    end
                end

                // Data entry goes in behind the status entry
                S_WDATA:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_FIN;
                end

                // Present the entry read from the head
                S_READ:
                begin
                    if (out_free)
                    begin
                        rsp_reg.result_kind <= RES_DEQUEUED;
                        rsp_reg.item_kind   <= rd_kind;
                        rsp_reg.item_tag    <= (rd_kind == KIND_DATA) ? 32'(rd_tag) : 32'd0;
                        rsp_reg.occupancy   <= 9'(count_reg);
                        rsp_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        rsp_reg.result_kind <= res_kind_reg;
                        rsp_reg.item_kind   <= KIND_DATA;
                        rsp_reg.item_tag    <= 32'd0;
                        rsp_reg.occupancy   <= 9'(count_reg);
                        rsp_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Count never exceeds the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // Head pointer stays inside the ring
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(QUEUE_DEPTH - 1))
        else $error("head pointer outside ring");

    // Non-dequeue responses carry no entry
    a_rsp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.result_kind != RES_DEQUEUED)
        |-> (rsp.item_kind == KIND_DATA && rsp.item_tag == 32'd0))
        else $error("entry fields set on non-dequeue response");

    // One request in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("second request taken while busy");

    // Arrivals and dequeues never touch the memory in the same cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("memory read and write in the same cycle");
`endif

endmodule

@@ sim/tail_drop_fifo_watermark_status_core_test.sv @@
// Self-checking testbench for tail_drop_fifo_watermark_status_core.
// Drives requests through a cycle-free queue predictor and checks each response in order.
// Depends on tdfws_pkg and the core module only.
`timescale 1ns / 1ps

module tail_drop_fifo_watermark_status_core_test;
    import tdfws_pkg::*;

    localparam int         SLOT_COUNT    = QUEUE_DEPTH_DEF;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         CYCLE_LIMIT   = 300000;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tag;
    } entry_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    // Predicted queue state and register copies
    entry_t     slots [SLOT_COUNT];
    logic [7:0] front_slot      = '0;
    int         held_entries    = 0;
    logic       congestion_sent = 1'b0;
    logic [7:0] drop_level      = CAPACITY_RST;
    logic [7:0] congest_level   = HIGH_MARK_RST;
    logic [7:0] relieve_level   = LOW_MARK_RST;

    rsp_t pending_results [$];
    int   fail_count  = 0;
    int   cycle_count = 0;
    int   tx_idle_pct = 20;
    int   rx_idle_pct = 5;
    int   stall_left  = 0;

    tail_drop_fifo_watermark_status_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Append an entry behind the last one held
    function automatic void append_entry(input logic [1:0] kind, input logic [31:0] tag);
        logic [7:0] pos;
        pos = front_slot + 8'(held_entries);
        slots[pos].kind = kind;
        slots[pos].tag  = tag;
        held_entries++;
    endfunction

    // Insert a status entry ahead of the oldest one; an empty queue takes it at the tail
    function automatic void prepend_status(input logic [1:0] kind);
        if (held_entries == 0)
        begin
            append_entry(kind, '0);
        end
        else
        begin
            front_slot = front_slot - 8'd1;
            slots[front_slot].kind = kind;
            slots[front_slot].tag  = '0;
            held_entries++;
        end
    endfunction

    // Advance the queue by one request and form its response
    function automatic rsp_t queue_response(input req_t item);
        rsp_t   result;
        entry_t head;
        logic   room;
        result = '0;
        if (item.opcode == OP_DEQUEUE)
        begin
            if (held_entries == 0)
            begin
                result.result_kind = RES_EMPTY;
            end
            else
            begin
                head = slots[front_slot];
                result.result_kind = RES_DEQUEUED;
                result.item_kind   = head.kind;
                result.item_tag    = (head.kind == KIND_DATA) ? head.tag : '0;
                front_slot = front_slot + 8'd1;
                held_entries--;
            end
        end
        else if (held_entries >= int'(drop_level) || held_entries >= SLOT_COUNT)
        begin
            result.result_kind = RES_DROPPED;
        end
        else
        begin
            room = (held_entries + 2 <= SLOT_COUNT);
            if (held_entries >= int'(congest_level) && !congestion_sent)
            begin
                if (room)
                begin
                    prepend_status(KIND_CONGESTED);
                    congestion_sent = 1'b1;
                end
            end
            else if (held_entries < int'(relieve_level) && congestion_sent)
            begin
                if (room)
                begin
                    prepend_status(KIND_RELIEVED);
                    congestion_sent = 1'b0;
                end
            end
            append_entry(KIND_DATA, item.packet_tag);
            result.result_kind = RES_ACCEPTED;
        end
        result.occupancy = 9'(held_entries);
        return result;
    endfunction

    // Check each response against the oldest prediction; stall the response side at random
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got %h", $time, rsp);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.result_kind !== want.result_kind)
                begin
                    $display("%0t: result_kind expected %0d got %0d",
                             $time, want.result_kind, rsp.result_kind);
                    fail_count++;
                end
                if (rsp.item_kind !== want.item_kind)
                begin
                    $display("%0t: item_kind expected %0d got %0d",
                             $time, want.item_kind, rsp.item_kind);
                    fail_count++;
                end
                if (rsp.item_tag !== want.item_tag)
                begin
                    $display("%0t: item_tag expected %h got %h",
                             $time, want.item_tag, rsp.item_tag);
                    fail_count++;
                end
                if (rsp.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d got %0d",
                             $time, want.occupancy, rsp.occupancy);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left--;
        end
        else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
        begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Send one request, with an optional gap first; valid stays high after the accept
    task automatic send_request(input logic op, input logic [31:0] tag);
        req_t item;
        item.opcode     = op;
        item.packet_tag = tag;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        pending_results.push_back(queue_response(item));
    endtask

    // Hold requests until every response is back and the core has settled
    task automatic hold_until_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the write enable is left high for back-to-back writes
    task automatic write_register(input logic [1:0] reg_index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        case (reg_index)
            CFG_CAPACITY:  drop_level    = value;
            CFG_HIGH_MARK: congest_level = value;
            CFG_LOW_MARK:  relieve_level = value;
            default:       ;
        endcase
    endtask

    task automatic program_marks(input logic [7:0] cap, input logic [7:0] high,
                                 input logic [7:0] low);
        write_register(CFG_CAPACITY, cap);
        write_register(CFG_HIGH_MARK, high);
        write_register(CFG_LOW_MARK, low);
        cfg_we <= 1'b0;
    endtask

    // Empty dequeues and extreme tags at reset settings
    task automatic test_empty_queue_and_tags();
        send_request(OP_DEQUEUE, $urandom);
        send_request(OP_ARRIVE, 32'h0000_0000);
        send_request(OP_ARRIVE, 32'hFFFF_FFFF);
        repeat (3) send_request(OP_DEQUEUE, $urandom);
    endtask

    // Congested status on the way up, drops at capacity, relieved status on the way down
    task automatic test_watermark_hysteresis();
        hold_until_drained();
        program_marks(8'd4, 8'd2, 8'd2);
        repeat (5) send_request(OP_ARRIVE, $urandom);
        repeat (3) send_request(OP_DEQUEUE, $urandom);
        send_request(OP_ARRIVE, $urandom);
        repeat (3) send_request(OP_DEQUEUE, $urandom);
    endtask

    // Status entries inserted while the queue is empty land at the tail
    task automatic test_status_into_empty_queue();
        hold_until_drained();
        program_marks(8'd3, 8'd0, 8'd0);
        send_request(OP_ARRIVE, $urandom);
        repeat (2) send_request(OP_DEQUEUE, $urandom);
        hold_until_drained();
        program_marks(8'd3, 8'd255, 8'd1);
        send_request(OP_ARRIVE, $urandom);
        repeat (2) send_request(OP_DEQUEUE, $urandom);
    endtask

    // Zero capacity drops everything; a write to the spare index changes nothing
    task automatic test_zero_capacity();
        hold_until_drained();
        write_register(CFG_UNUSED, 8'($urandom));
        program_marks(8'd0, 8'd0, 8'd0);
        repeat (2) send_request(OP_ARRIVE, $urandom);
        send_request(OP_DEQUEUE, $urandom);
    endtask

    // Fill the store to all 256 entries, then drain it past empty
    task automatic test_full_store();
        hold_until_drained();
        if (congestion_sent)
        begin
            program_marks(8'd255, 8'd255, 8'd1);
            send_request(OP_ARRIVE, $urandom);
            repeat (2) send_request(OP_DEQUEUE, $urandom);
            hold_until_drained();
        end
        program_marks(8'd255, 8'd254, 8'd0);
        tx_idle_pct = 20;
        rx_idle_pct = 10;
        repeat (258) send_request(OP_ARRIVE, $urandom);
        repeat (258) send_request(OP_DEQUEUE, $urandom);
    endtask

    // Run one setting with alternating fill and drain stretches of random requests
    task automatic run_traffic(input int count, input logic [7:0] cap, input logic [7:0] high,
                               input logic [7:0] low, input logic quiet);
        int   stretch_left;
        logic filling;
        logic op;
        stretch_left = 0;
        filling      = 1'b0;
        hold_until_drained();
        program_marks(cap, high, low);
        for (int n = 0; n < count; n++)
        begin
            if (stretch_left == 0)
            begin
                filling      = !filling;
                stretch_left = $urandom_range(8, 40);
                tx_idle_pct  = quiet ? 0 : 20 * $urandom_range(0, 2);
                rx_idle_pct  = quiet ? 0 : 5 * $urandom_range(0, 3);
            end
            stretch_left--;
            op = ($urandom_range(0, 99) < (filling ? 85 : 25)) ? OP_ARRIVE : OP_DEQUEUE;
            send_request(op, $urandom);
            // hold the sender until everything is back once per setting
            if (n == count / 2)
                hold_until_drained();
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(120, 8'd8, 8'd6, 8'd2, 1'b0);
        run_traffic(120, 8'd20, 8'd16, 8'd5, 1'b0);
        run_traffic(60, 8'd1, 8'd0, 8'd0, 1'b0);
        run_traffic(120, 8'd60, 8'd10, 8'd40, 1'b0);
        run_traffic(120, CAPACITY_RST, HIGH_MARK_RST, LOW_MARK_RST, 1'b0);
        run_traffic(100, 8'd255, 8'd255, 8'd255, 1'b1);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue_and_tags();
        test_watermark_hysteresis();
        test_status_into_empty_queue();
        test_zero_capacity();
        test_full_store();
        test_random_traffic();
        hold_until_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
design/tdfws_pkg.sv
design/tail_drop_fifo_watermark_status_core.sv
sim/tail_drop_fifo_watermark_status_core_test.sv
